// File: rtl/iepmp_pkg.sv
`default_nettype none

package iepmp_pkg;

  localparam int DefaultMaxItems = 64;
  localparam int PriceW          = 16;
  localparam int TotalW          = 28;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef struct packed {
    logic [PriceW-1:0] price;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [TotalW-1:0] total_profit;
    logic              too_many;
  } out_word_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkIssue,
    BkDrain,
    BkFinish
  } back_state_e;

endpackage

`default_nettype wire

// File: rtl/iepmp_ram.sv
`default_nettype none

module iepmp_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/iepmp_front.sv
`default_nettype none

module iepmp_front #(
  parameter int MaxItems = 64,
  parameter int AddrW    = (MaxItems > 1) ? $clog2(MaxItems) : 1,
  parameter int CountW   = $clog2(MaxItems + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire iepmp_pkg::in_word_t       in_word_i,
  input  wire logic                      hold_i,
  output logic                           price_we_o,
  output logic [AddrW-1:0]               price_waddr_o,
  output logic [iepmp_pkg::PriceW-1:0]   price_wdata_o,
  output logic                           job_push_o,
  output logic [CountW-1:0]              job_n_o,
  output logic                           job_too_many_o
);
  import iepmp_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              accept, full, store;

  assign in_stall_o = hold_i;
  assign accept     = in_valid_i && !hold_i;
  assign full       = (count_q == CountW'(MaxItems));
  assign store      = accept && !full;

  assign price_we_o    = store;
  assign price_waddr_o = count_q[AddrW-1:0];
  assign price_wdata_o = in_word_i.price;

  // row closes on the word that carries last
  assign job_push_o     = accept && in_word_i.last;
  assign job_n_o        = store ? count_q + CountW'(1) : count_q;
  assign job_too_many_o = ovf_q || (accept && full);

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (in_word_i.last) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/iepmp_queue.sv
`default_nettype none

module iepmp_queue #(
  parameter int Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o
);

  logic [Width-1:0] slot_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       fill_q;
  logic             do_push, do_pop;

  assign empty_o = (fill_q == 2'd0);
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i && (fill_q != 2'd2);
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/iepmp_back.sv
`default_nettype none

module iepmp_back #(
  parameter int MaxItems = 64,
  parameter int AddrW    = (MaxItems > 1) ? $clog2(MaxItems) : 1,
  parameter int CountW   = $clog2(MaxItems + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      job_valid_i,
  input  wire logic [CountW-1:0]         job_n_i,
  input  wire logic                      job_too_many_i,
  output logic                           job_pop_o,
  output logic [AddrW-1:0]               price_raddr_a_o,
  output logic [AddrW-1:0]               price_raddr_b_o,
  input  wire logic [iepmp_pkg::PriceW-1:0] price_a_i,
  input  wire logic [iepmp_pkg::PriceW-1:0] price_b_i,
  output logic                           busy_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output iepmp_pkg::out_word_t           out_word_o
);
  import iepmp_pkg::*;

  // partial totals never exceed price max times 1+2+..+MaxItems
  localparam int PartW = PriceW + $clog2(MaxItems * (MaxItems + 1) / 2 + 1);
  localparam int ProdW = PriceW + CountW;

  back_state_e state_q, state_d;

  logic [CountW-1:0] n_q, len_q, k_q, day;
  logic              too_many_q;
  logic              issue, pop, load_out, drained;

  // read-data stage
  logic              s1_v_q, s1_cell_q;
  logic [CountW-1:0] s1_waddr_q;
  logic [PartW-1:0]  row_rd, prev_row_q;

  // product stage
  logic              s2_v_q;
  logic [CountW-1:0] s2_waddr_q;
  logic [ProdW-1:0]  prod_l_q, prod_r_q;
  logic [PartW-1:0]  row_l_q, row_r_q;
  logic [PartW-1:0]  sum_l, sum_r, best;

  logic [PartW-1:0]  res_q;
  logic              out_valid_q;
  out_word_t         out_word_q;

  assign day     = n_q - len_q + CountW'(1);
  assign drained = !s1_v_q && !s2_v_q;
  assign busy_o  = (state_q != BkIdle);

  // cell i = k-1 uses price[i] and price[i+len-1]
  assign price_raddr_a_o = AddrW'(k_q - CountW'(1));
  assign price_raddr_b_o = AddrW'(k_q + len_q - CountW'(2));

  iepmp_ram #(
    .Width (PartW),
    .Depth (MaxItems),
    .AddrW (AddrW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s2_v_q),
    .waddr_i (s2_waddr_q[AddrW-1:0]),
    .wdata_i (best),
    .raddr_i (k_q[AddrW-1:0]),
    .rdata_o (row_rd)
  );

  assign sum_l = PartW'(prod_l_q) + row_l_q;
  assign sum_r = PartW'(prod_r_q) + row_r_q;
  assign best  = (sum_l > sum_r) ? sum_l : sum_r;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (job_valid_i) begin
          state_d = BkIssue;
        end
      end
      BkIssue: begin
        if (k_q == day) begin
          state_d = BkDrain;
        end
      end
      BkDrain: begin
        if (drained) begin
          state_d = (len_q == n_q) ? BkFinish : BkIssue;
        end
      end
      BkFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    issue    = 1'b0;
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BkIdle:   pop      = job_valid_i;
      BkIssue:  issue    = 1'b1;
      BkFinish: load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign job_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      n_q         <= '0;
      too_many_q  <= 1'b0;
      len_q       <= '0;
      k_q         <= '0;
      s1_v_q      <= 1'b0;
      s1_cell_q   <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      s1_v_q    <= issue;
      s1_cell_q <= issue && (k_q != '0);
      s2_v_q    <= s1_cell_q;
      if (pop) begin
        n_q        <= job_n_i;
        too_many_q <= job_too_many_i;
        len_q      <= CountW'(1);
        k_q        <= '0;
      end else if (issue) begin
        k_q <= k_q + CountW'(1);
      end else if ((state_q == BkDrain) && drained && (len_q != n_q)) begin
        len_q <= len_q + CountW'(1);
        k_q   <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_waddr_q <= k_q - CountW'(1);
    if (s1_v_q) begin
      prev_row_q <= row_rd;
    end
    s2_waddr_q <= s1_waddr_q;
    prod_l_q   <= ProdW'(day) * ProdW'(price_a_i);
    prod_r_q   <= ProdW'(day) * ProdW'(price_b_i);
    // single-item pass has no inner interval
    row_l_q    <= (len_q == CountW'(1)) ? '0 : row_rd;
    row_r_q    <= (len_q == CountW'(1)) ? '0 : prev_row_q;
    if (s2_v_q && (len_q == n_q)) begin
      res_q <= best;
    end
    if (load_out) begin
      out_word_q.total_profit <= (64'(res_q) > 64'(TotalMax)) ? TotalMax : TotalW'(res_q);
      out_word_q.too_many     <= too_many_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// File: rtl/interval_end_pick_max_profit.sv
// Load: one price word per cycle, stalled while a row is being solved.
// Solve: after the word with last, a pass per len = 1..n over the row RAM,
//   then the output register is loaded; one result word per row.
// Throughput is set by the single read/write port pair of the row RAM.
// Reset (async, active low) clears counts, flags, FSM and valid bits only.
`default_nettype none

module interval_end_pick_max_profit #(
  parameter int MaxItems = iepmp_pkg::DefaultMaxItems
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire iepmp_pkg::in_word_t  in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output iepmp_pkg::out_word_t      out_word_o
);
  import iepmp_pkg::*;

  localparam int AddrW  = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int CountW = $clog2(MaxItems + 1);

  // front -> price store
  logic              price_we;
  logic [AddrW-1:0]  price_waddr;
  logic [PriceW-1:0] price_wdata;

  // front -> job queue -> back
  logic              job_push, job_pop, job_empty;
  logic [CountW-1:0] push_n, pop_n;
  logic              push_too_many, pop_too_many;

  // back read side of the price store
  logic [AddrW-1:0]  raddr_a, raddr_b;
  logic [PriceW-1:0] price_a, price_b;
  logic              back_busy;
  logic              hold;

  // price store belongs to the back end from row close to result
  assign hold = !job_empty || back_busy;

  iepmp_front #(
    .MaxItems (MaxItems),
    .AddrW    (AddrW),
    .CountW   (CountW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_word_i      (in_word_i),
    .hold_i         (hold),
    .price_we_o     (price_we),
    .price_waddr_o  (price_waddr),
    .price_wdata_o  (price_wdata),
    .job_push_o     (job_push),
    .job_n_o        (push_n),
    .job_too_many_o (push_too_many)
  );

  // two copies of the price row: left-end and right-end reads per cycle
  iepmp_ram #(
    .Width (PriceW),
    .Depth (MaxItems),
    .AddrW (AddrW)
  ) u_price_a (
    .clk_i   (clk_i),
    .we_i    (price_we),
    .waddr_i (price_waddr),
    .wdata_i (price_wdata),
    .raddr_i (raddr_a),
    .rdata_o (price_a)
  );

  iepmp_ram #(
    .Width (PriceW),
    .Depth (MaxItems),
    .AddrW (AddrW)
  ) u_price_b (
    .clk_i   (clk_i),
    .we_i    (price_we),
    .waddr_i (price_waddr),
    .wdata_i (price_wdata),
    .raddr_i (raddr_b),
    .rdata_o (price_b)
  );

  iepmp_queue #(
    .Width (CountW + 1)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i ({push_n, push_too_many}),
    .pop_i   (job_pop),
    .rdata_o ({pop_n, pop_too_many}),
    .empty_o (job_empty)
  );

  iepmp_back #(
    .MaxItems (MaxItems),
    .AddrW    (AddrW),
    .CountW   (CountW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (!job_empty),
    .job_n_i         (pop_n),
    .job_too_many_i  (pop_too_many),
    .job_pop_o       (job_pop),
    .price_raddr_a_o (raddr_a),
    .price_raddr_b_o (raddr_b),
    .price_a_i       (price_a),
    .price_b_i       (price_b),
    .busy_o          (back_busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_word_o      (out_word_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/interval_end_pick_max_profit_test.sv
`timescale 1ns / 1ps

module interval_end_pick_max_profit_test;
  import iepmp_pkg::*;

  localparam int MaxItems      = DefaultMaxItems;
  localparam int WordBudget    = 1650;
  localparam int IdleMax       = 14;
  localparam int HoldOffCycles = 600;
  // Slowest solve of a full row, plus the output register.
  localparam int SolveCycles   = MaxItems * (MaxItems + 1) / 2 + 4 * MaxItems + 2;
  localparam int DrainCycles   = SolveCycles + 2 * IdleMax;
  // Longest quiet stretch of a good run: a full solve behind a long output hold
  // and the worst gaps on both sides, taken four times over.
  localparam int WatchdogLimit = 4 * (SolveCycles + HoldOffCycles + 2 * IdleMax);

  typedef logic [PriceW-1:0] price_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  interval_end_pick_max_profit u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  always #5ns clk_i = ~clk_i;

  // Shadow of the row being loaded, as the block should see it.
  price_t    row_prices [MaxItems];
  int        row_len     = 0;
  bit        row_dropped = 1'b0;
  // Totals still owed by the block, oldest first.
  out_word_t expected_totals [$];

  int send_idle_max = 0;
  int recv_idle_max = 0;
  bit hold_off_req  = 1'b0;
  bit stim_done     = 1'b0;

  int mismatches   = 0;
  int words_sent   = 0;
  int rows_sent    = 0;
  int rows_full    = 0;
  int rows_clipped = 0;
  int results_seen = 0;

  // Best selling order, bottom-up over interval lengths. After the pass for
  // length len, best[i] holds the best total for the len items from i on,
  // which are sold on days n-len+1 .. n.
  function automatic logic [TotalW-1:0] best_sale_total(input int n);
    longint unsigned best [MaxItems];
    longint unsigned day, take_left, take_right;
    if (n == 0) begin
      return '0;
    end
    for (int i = 0; i < n; i++) begin
      best[i] = longint'(n) * row_prices[i];
    end
    for (int len = 2; len <= n; len++) begin
      day = longint'(n - len + 1);
      for (int i = 0; i + len <= n; i++) begin
        take_left  = day * row_prices[i] + best[i + 1];
        take_right = day * row_prices[i + len - 1] + best[i];
        best[i]    = (take_left > take_right) ? take_left : take_right;
      end
    end
    if (best[0] > longint'(TotalMax)) begin
      return TotalMax;
    end
    return TotalW'(best[0]);
  endfunction

  // Called once per accepted input word, in acceptance order.
  function automatic void note_accepted_word(input price_t price, input bit last);
    out_word_t want;
    words_sent++;
    if (row_len < MaxItems) begin
      row_prices[row_len] = price;
      row_len++;
    end else begin
      // store full: word is dropped, row gets flagged
      row_dropped = 1'b1;
    end
    if (last) begin
      want.total_profit = best_sale_total(row_len);
      want.too_many     = row_dropped;
      expected_totals.insert(expected_totals.size(), want);
      rows_sent++;
      if (row_len == MaxItems) begin
        rows_full++;
      end
      if (row_dropped) begin
        rows_clipped++;
      end
      row_len     = 0;
      row_dropped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    results_seen++;
    if (expected_totals.size() == 0) begin
      report_mismatch($sformatf("result word %0d arrived with none owed, total %0d",
                                results_seen, got.total_profit));
      return;
    end
    want = expected_totals.pop_front();
    if (got.total_profit !== want.total_profit) begin
      report_mismatch($sformatf("result word %0d: total_profit %0d, expected %0d",
                                results_seen, got.total_profit, want.total_profit));
    end
    if (got.too_many !== want.too_many) begin
      report_mismatch($sformatf("result word %0d: too_many %0b, expected %0b",
                                results_seen, got.too_many, want.too_many));
    end
  endtask

  // Sender: random gap, then hold the word until the block takes it.
  // valid only drops when a gap follows, so it never toggles within a step.
  task automatic send_word(input price_t price, input bit last);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= '{price: price, last: last};
    do @(posedge clk_i); while (in_stall);
    note_accepted_word(price, last);
  endtask

  // Up to eight prices, first price in the top slice used.
  task automatic send_short_row(input int n, input logic [8*PriceW-1:0] prices);
    for (int i = 0; i < n; i++) begin
      send_word(prices[(n - 1 - i) * PriceW +: PriceW], i == n - 1);
    end
  endtask

  function automatic price_t draw_price();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return price_t'($urandom_range(0, 15));
      3:       return price_t'($urandom_range(65520, 65535));
      default: return price_t'($urandom);
    endcase
  endfunction

  // Mostly short rows; full and overrunning rows are rare since they are slow.
  function automatic int draw_row_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 8);
    if (pick < 92) return $urandom_range(9, 40);
    if (pick < 97) return $urandom_range(41, MaxItems - 1);
    if (pick < 99) return MaxItems;
    return $urandom_range(MaxItems + 1, MaxItems + 8);
  endfunction

  task automatic send_random_row(input int n);
    for (int i = 0; i < n; i++) begin
      send_word(draw_price(), i == n - 1);
    end
  endtask

  // Single words, pairs that favor one end, alternating extremes, a ramp.
  task automatic test_short_rows();
    send_idle_max = 0;
    recv_idle_max = 0;
    send_short_row(1, {16'h0000});
    send_short_row(1, {16'hFFFF});
    send_short_row(2, {16'h0001, 16'hFFFF});
    send_short_row(2, {16'hFFFF, 16'h0001});
    send_idle_max = IdleMax;
    recv_idle_max = IdleMax;
    send_short_row(3, {16'hFFFF, 16'h0000, 16'hFFFF});
    send_short_row(3, {16'h0000, 16'hFFFF, 16'h0000});
    send_short_row(4, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    send_short_row(5, {16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005});
  endtask

  // Full store and overruns: largest total, dropped word with last, extras, all zeros.
  task automatic test_full_and_clipped_rows();
    int extra;
    send_idle_max = 2;
    recv_idle_max = IdleMax;
    for (int i = 0; i < MaxItems; i++) begin
      send_word('1, i == MaxItems - 1);
    end
    // last rides on the first word past a full store
    for (int i = 0; i <= MaxItems; i++) begin
      send_word(draw_price(), i == MaxItems);
    end
    extra = $urandom_range(2, 8);
    for (int i = 0; i < MaxItems + extra; i++) begin
      send_word(draw_price(), i == MaxItems + extra - 1);
    end
    for (int i = 0; i < MaxItems; i++) begin
      send_word('0, i == MaxItems - 1);
    end
  endtask

  // Receiver sits on a result for a long stretch while short rows keep
  // coming, so the block backs up and stalls its input.
  task automatic test_output_hold();
    send_idle_max = 0;
    recv_idle_max = 3;
    hold_off_req  = 1'b1;
    for (int r = 0; r < 8; r++) begin
      send_random_row($urandom_range(1, 4));
    end
  endtask

  task automatic test_random_rows();
    while (words_sent < WordBudget) begin
      // new idle profile every few rows, including runs with no gaps at all
      if (rows_sent % 8 == 0) begin
        case ($urandom_range(0, 4))
          0: begin send_idle_max = 0;       recv_idle_max = 0;       end
          1: begin send_idle_max = IdleMax; recv_idle_max = IdleMax; end
          2: begin send_idle_max = 0;       recv_idle_max = IdleMax; end
          3: begin send_idle_max = IdleMax; recv_idle_max = 0;       end
          default: begin send_idle_max = 2; recv_idle_max = 2;       end
        endcase
      end
      send_random_row(draw_row_len());
    end
  endtask

  // Receiver: checks each accepted result word, then stalls for a drawn
  // number of cycles; a requested hold-off overrides that.
  int recv_wait = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        check_result(out_word);
        recv_wait = $urandom_range(0, recv_idle_max);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: counts cycles with no word moving while work is outstanding.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)
        || (stim_done && expected_totals.size() == 0)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("ERROR: no word moved for %0d cycles, %0d results owed",
               quiet_cycles, expected_totals.size());
      $display("interval_end_pick_max_profit_test failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_rows();
    test_full_and_clipped_rows();
    test_output_hold();
    test_random_rows();

    in_valid     <= 1'b0;
    stim_done     = 1'b1;
    recv_idle_max = 0;
    while (expected_totals.size() != 0) @(posedge clk_i);
    // room for a stray extra result after the last solve
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d words in %0d rows; %0d rows filled the store, %0d overran it.",
             words_sent, rows_sent, rows_full, rows_clipped);
    $display("Checked %0d result words under random gaps and a long output hold.",
             results_seen);
    if (mismatches == 0) begin
      $display("interval_end_pick_max_profit_test passed");
    end else begin
      $display("interval_end_pick_max_profit_test failed");
    end
    $finish;
  end

endmodule
